@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Every macro samples on clk and is
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/lgs_pkg.sv @@
// ----------------------------------------------------------------------------
// lgs_pkg
// Constants and types for the streaming Life generation block.
// ----------------------------------------------------------------------------
package lgs_pkg;

    // Grid limits.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Fixed field widths.
    localparam int CFG_W  = 11;
    localparam int POS_W  = 10;
    localparam int LIVE_W = 21;
    localparam int GEN_W  = 32;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Widths that follow from the grid limits.
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW    = $clog2(MAX_WIDTH + 1);
    localparam int EH    = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

    // Line store entry: the two rows above the arriving cell.
    localparam int RAM_W = 2;

    // Register indexes, selected by paddr[2].
    typedef enum logic {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } reg_idx_t;

    // One column of the 3x3 window, top row first.
    typedef struct packed {
        logic top;
        logic mid;
        logic bot;
    } win_col_t;

endpackage

@@ src/lgs_ram.sv @@
// ----------------------------------------------------------------------------
// lgs_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module lgs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/life_generation_stream_top.sv @@
// ----------------------------------------------------------------------------
// life_generation_stream_top
// One generation of B3/S23 Life over a raster cell stream with a dead border.
//
//   Channel   Handshake                  Payload
//   cell      cell_valid / cell_stall    alive
//   result    result_valid / result_stall next_alive, cell_row, cell_col,
//                                        frame_last, live_total,
//                                        generation_index
//   config    APB psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One cell transaction per cycle while cell_stall is low; the line store RAM is
// read when a cell is accepted and written back as the window stage advances,
// with forwarding on equal columns. A result moves from the window stage into the
// result register; its window completes width+1 cells after the cell itself.
// Reset clears control state only; the line store is never cleared, since
// every neighbor it could supply from stale data lies outside the grid.
// A stalled result holds the output register; cells are still taken until
// the one-entry window stage behind it is full.
// ----------------------------------------------------------------------------
module life_generation_stream_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // cell channel
    input  logic                        cell_valid,
    output logic                        cell_stall,
    input  logic                        alive,
    // result channel
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        next_alive,
    output logic [lgs_pkg::POS_W-1:0]   cell_row,
    output logic [lgs_pkg::POS_W-1:0]   cell_col,
    output logic                        frame_last,
    output logic [lgs_pkg::LIVE_W-1:0]  live_total,
    output logic [lgs_pkg::GEN_W-1:0]   generation_index,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lgs_pkg::ADDR_W-1:0]  paddr,
    input  logic [lgs_pkg::DATA_W-1:0]  pwdata,
    output logic [lgs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    import lgs_pkg::*;

`include "assert_macros.svh"

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] grid_width_reg, grid_width_next;
    logic [CFG_W-1:0] grid_height_reg, grid_height_next;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;
    logic [EW-1:0]    eff_w;
    logic [EH-1:0]    eff_h;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_comb
    begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_GRID_WIDTH:  grid_width_next  = pwdata[CFG_W-1:0];
                REG_GRID_HEIGHT: grid_height_next = pwdata[CFG_W-1:0];
                default:         grid_width_next  = grid_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_GRID_WIDTH:  prdata = DATA_W'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = DATA_W'(grid_height_reg);
            default:         prdata = '0;
        endcase
    end

    // Out-of-range register values are clamped to the supported grid.
    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            eff_w = EW'(1);
        end
        else if (32'(grid_width_reg) > MAX_WIDTH)
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW'(grid_width_reg);
        end

        if (grid_height_reg == '0)
        begin
            eff_h = EH'(1);
        end
        else if (32'(grid_height_reg) > MAX_HEIGHT)
        begin
            eff_h = EH'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = EH'(grid_height_reg);
        end
    end

    // ------------------------------------------------------------------
    // Arrival stage: position tracking and line store read
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] arrival_row_reg, arrival_row_next;
    logic [COL_W-1:0] arrival_col_reg, arrival_col_next;
    logic             cell_acc;
    logic             col_last;
    logic             a_cur;
    logic             a_have;
    logic             a_last;
    logic [ROW_W-1:0] a_cr;
    logic [COL_W-1:0] a_cc;
    logic [ROW_W-1:0] row_h;

    // Window stage registers
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_have_reg;
    logic             s1_last_reg;
    logic             s1_cur_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_cr_reg;
    logic [COL_W-1:0] s1_cc_reg;
    logic             s1_top_dead_reg;
    logic             s1_bot_dead_reg;
    logic             s1_left_dead_reg;
    logic             s1_right_dead_reg;
    logic             fwd_reg;
    logic [RAM_W-1:0] fwd_data_reg;
    logic             s1_go;
    logic             s1_adv;
    logic             result_valid_reg, result_valid_next;

    assign row_h    = ROW_W'(eff_h);
    assign col_last = (EW'(arrival_col_reg) == (eff_w - EW'(1)));

    // Padding rows are stored as dead cells.
    assign a_cur  = (arrival_row_reg < row_h) ? alive : 1'b0;
    assign a_have = (arrival_row_reg >= ROW_W'(2)) ||
                    ((arrival_row_reg == ROW_W'(1)) && (arrival_col_reg != '0));
    assign a_last = (arrival_row_reg == (row_h + ROW_W'(1)));

    // At column zero the reported cell is the end of the row two rows up.
    always_comb
    begin
        if (arrival_col_reg == '0)
        begin
            a_cr = arrival_row_reg - ROW_W'(2);
            a_cc = COL_W'(eff_w - EW'(1));
        end
        else
        begin
            a_cr = arrival_row_reg - ROW_W'(1);
            a_cc = arrival_col_reg - COL_W'(1);
        end
    end

    assign s1_go      = !result_valid_reg || !result_stall;
    assign s1_adv     = s1_valid_reg && s1_go;
    assign cell_stall = s1_valid_reg && !s1_go;
    assign cell_acc   = cell_valid && !cell_stall;

    always_comb
    begin
        arrival_row_next = arrival_row_reg;
        arrival_col_next = arrival_col_reg;
        if (cfg_wr)
        begin
            arrival_row_next = '0;
            arrival_col_next = '0;
        end
        else if (cell_acc)
        begin
            if (a_last)
            begin
                arrival_row_next = '0;
                arrival_col_next = '0;
            end
            else if (col_last)
            begin
                arrival_col_next = '0;
                arrival_row_next = arrival_row_reg + ROW_W'(1);
            end
            else
            begin
                arrival_col_next = arrival_col_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cell_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Line store: entry per column holds {row r-2, row r-1}
    // ------------------------------------------------------------------
    logic [RAM_W-1:0] ram_rd_data;
    logic [RAM_W-1:0] ram_wr_data;
    logic [RAM_W-1:0] col_above;
    win_col_t         new_col;

    assign col_above   = fwd_reg ? fwd_data_reg : ram_rd_data;
    assign new_col     = '{top: col_above[1], mid: col_above[0], bot: s1_cur_reg};
    assign ram_wr_data = {new_col.mid, new_col.bot};

    lgs_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (ram_wr_data),
        .rd_en   (cell_acc),
        .rd_addr (arrival_col_reg),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Window and rule evaluation
    // ------------------------------------------------------------------
    win_col_t win_l_reg, win_c_reg;
    win_col_t left_m, right_m;
    logic     top_ok, bot_ok;
    logic [7:0] nb_bits;
    logic [3:0] nb_sum;
    logic       center;
    logic       nxt;

    assign top_ok = !s1_top_dead_reg;
    assign bot_ok = !s1_bot_dead_reg;
    assign left_m  = s1_left_dead_reg  ? win_col_t'('0) : win_l_reg;
    assign right_m = s1_right_dead_reg ? win_col_t'('0) : new_col;
    assign center  = win_c_reg.mid;

    assign nb_bits = {left_m.top & top_ok,  left_m.mid,  left_m.bot & bot_ok,
                      win_c_reg.top & top_ok,            win_c_reg.bot & bot_ok,
                      right_m.top & top_ok, right_m.mid, right_m.bot & bot_ok};

    always_comb
    begin
        nb_sum = '0;
        for (int i = 0; i < 8; i++)
        begin
            nb_sum = nb_sum + 4'(nb_bits[i]);
        end
    end

    assign nxt = center ? ((nb_sum == 4'd2) || (nb_sum == 4'd3)) : (nb_sum == 4'd3);

    // ------------------------------------------------------------------
    // Frame counters and result register
    // ------------------------------------------------------------------
    logic [LIVE_W-1:0] live_counter_reg, live_counter_next;
    logic [GEN_W-1:0]  gen_counter_reg, gen_counter_next;
    logic [LIVE_W-1:0] live_inc;
    logic              res_load;

    logic              next_alive_reg;
    logic [POS_W-1:0]  cell_row_reg;
    logic [POS_W-1:0]  cell_col_reg;
    logic              frame_last_reg;
    logic [LIVE_W-1:0] live_total_reg;
    logic [GEN_W-1:0]  generation_index_reg;

    assign res_load = s1_adv && s1_have_reg;
    assign live_inc = live_counter_reg + LIVE_W'(nxt);

    always_comb
    begin
        live_counter_next = live_counter_reg;
        gen_counter_next  = gen_counter_reg;
        if (cfg_wr)
        begin
            live_counter_next = '0;
        end
        else if (res_load)
        begin
            if (s1_last_reg)
            begin
                live_counter_next = '0;
                gen_counter_next  = gen_counter_reg + GEN_W'(1);
            end
            else
            begin
                live_counter_next = live_inc;
            end
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (s1_go)
        begin
            result_valid_next = s1_valid_reg && s1_have_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg   <= CFG_W'(64);
            grid_height_reg  <= CFG_W'(64);
            arrival_row_reg  <= '0;
            arrival_col_reg  <= '0;
            s1_valid_reg     <= 1'b0;
            live_counter_reg <= '0;
            gen_counter_reg  <= '0;
            result_valid_reg <= 1'b0;
            win_l_reg        <= '0;
            win_c_reg        <= '0;
        end
        else
        begin
            grid_width_reg   <= grid_width_next;
            grid_height_reg  <= grid_height_next;
            arrival_row_reg  <= arrival_row_next;
            arrival_col_reg  <= arrival_col_next;
            s1_valid_reg     <= s1_valid_next;
            live_counter_reg <= live_counter_next;
            gen_counter_reg  <= gen_counter_next;
            result_valid_reg <= result_valid_next;
            if (s1_adv)
            begin
                win_l_reg <= win_c_reg;
                win_c_reg <= new_col;
            end
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (cell_acc)
        begin
            s1_have_reg       <= a_have;
            s1_last_reg       <= a_last;
            s1_cur_reg        <= a_cur;
            s1_col_reg        <= arrival_col_reg;
            s1_cr_reg         <= a_cr;
            s1_cc_reg         <= a_cc;
            s1_top_dead_reg   <= (a_cr == '0);
            s1_bot_dead_reg   <= (a_cr == (row_h - ROW_W'(1)));
            s1_left_dead_reg  <= (a_cc == '0);
            // The right neighbor lies past the last column exactly when the
            // arriving cell opens a new row.
            s1_right_dead_reg <= (arrival_col_reg == '0);
            // The write-back of the cell ahead lands on the same edge as this
            // read; take its data instead of the stale RAM word.
            fwd_reg           <= s1_adv && (s1_col_reg == arrival_col_reg);
            fwd_data_reg      <= ram_wr_data;
        end
        if (res_load)
        begin
            next_alive_reg       <= nxt;
            cell_row_reg         <= POS_W'(s1_cr_reg);
            cell_col_reg         <= POS_W'(s1_cc_reg);
            frame_last_reg       <= s1_last_reg;
            live_total_reg       <= s1_last_reg ? live_inc : '0;
            generation_index_reg <= s1_last_reg ? (gen_counter_reg + GEN_W'(1)) : '0;
        end
    end

    assign result_valid     = result_valid_reg;
    assign next_alive       = next_alive_reg;
    assign cell_row         = cell_row_reg;
    assign cell_col         = cell_col_reg;
    assign frame_last       = frame_last_reg;
    assign live_total       = live_total_reg;
    assign generation_index = generation_index_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CHK_IMPLY(a_col_in_range, 1'b1, (EW'(arrival_col_reg) < eff_w), "column past grid width")
    `CHK_NEXT(a_accept_fills_window, cell_acc, s1_valid_reg, "accepted cell lost before window")
    `CHK_NEXT(a_frame_restarts_count, (res_load && s1_last_reg), (live_counter_reg == '0), "live count not restarted after frame")

endmodule
